>>> sv/mmf3_pkg.sv
`default_nettype none

package mmf3_pkg;

  // Line buffer geometry
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 4096;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);

  // Field and register widths
  localparam int PIX_W    = 8;
  localparam int COL_W    = 9;
  localparam int ROW_W    = 12;
  localparam int WIDTH_W  = 10;
  localparam int HEIGHT_W = 13;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 1;

  // Register reset values
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(496);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(372);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] filtered;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             frame_last;
  } out_word_t;

  // Median of three samples
  function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) begin
      return lo;
    end else if (c >= hi) begin
      return hi;
    end
    return c;
  endfunction

  function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

>>> sv/max_median_filter_3x3_top.sv
`default_nettype none

// Directional-median maximum filter, 3x3, for a raster-order 8-bit luma stream.
// Input channel (in_valid/in_ready/in_data) takes one pixel word per cycle while
// in_ready is high; frame_start on a word restarts the row/column position at zero.
// Output channel (out_valid/out_ready/out_data) gives one word per interior
// pixel: the max of the vertical, horizontal and both diagonal medians through
// the centre, the centre's row and column, and frame_last on the final one.
// Border pixels give no word.
// Throughput: one pixel per cycle unless the output stalls. Both line buffers share one
// 512 x 16 synchronous RAM: one read and one write per cycle, with a bypass
// when back-to-back pixels hit the same column.
// Pipeline: an accepted pixel passes the RAM read stage, the median stage and
// the output register before its result word is valid.
// Stall: when out_valid is high and out_ready low the whole pipeline holds and
// in_ready drops; it rises again in the cycle the output word is taken.
// Config: cfg_we writes image_width (index 0) or image_height (index 1) at
// once; write only while idle. Reset: counters and window clear, registers
// return to 496 x 372, RAM contents stay undefined until written.
module max_median_filter_3x3_top
  import mmf3_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_word_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_word_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam logic [WIDTH_W-1:0]  W_MIN = WIDTH_W'(3);
  localparam logic [WIDTH_W-1:0]  W_MAX = WIDTH_W'(MAX_WIDTH);
  localparam logic [HEIGHT_W-1:0] H_MIN = HEIGHT_W'(3);
  localparam logic [HEIGHT_W-1:0] H_MAX = HEIGHT_W'(MAX_HEIGHT);

  // Clamped frame size
  logic [WIDTH_W-1:0]  width_eff;
  logic [HEIGHT_W-1:0] height_eff;
  logic [WIDTH_W-1:0]  cfg_w_raw;

  assign cfg_w_raw = cfg_data[WIDTH_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= WIDTH_RESET;
      height_eff <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          if (cfg_w_raw < W_MIN) begin
            width_eff <= W_MIN;
          end else if (cfg_w_raw > W_MAX) begin
            width_eff <= W_MAX;
          end else begin
            width_eff <= cfg_w_raw;
          end
        end
        CFG_IMAGE_HEIGHT: begin
          if (cfg_data < H_MIN) begin
            height_eff <= H_MIN;
          end else if (cfg_data > H_MAX) begin
            height_eff <= H_MAX;
          end else begin
            height_eff <= cfg_data;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Pipeline advance: the output register is empty or being drained
  logic advance;
  logic accept;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && advance;

  // Position counters
  logic [COL_W-1:0]    col_count;
  logic [ROW_W-1:0]    row_count;
  logic [COL_W-1:0]    c_cur;
  logic [ROW_W-1:0]    r_cur;
  logic [WIDTH_W-1:0]  c_plus;
  logic [HEIGHT_W-1:0] r_plus;
  logic                row_end;
  logic                frame_end;

  always_comb begin
    c_cur     = in_data.frame_start ? '0 : col_count;
    r_cur     = in_data.frame_start ? '0 : row_count;
    c_plus    = WIDTH_W'(c_cur) + WIDTH_W'(1);
    r_plus    = HEIGHT_W'(r_cur) + HEIGHT_W'(1);
    row_end   = c_plus >= width_eff;
    frame_end = row_end && (r_plus >= height_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (frame_end) begin
        col_count <= '0;
        row_count <= '0;
      end else if (row_end) begin
        col_count <= '0;
        row_count <= r_plus[ROW_W-1:0];
      end else begin
        col_count <= c_plus[COL_W-1:0];
      end
    end
  end

  // Line RAM: upper byte holds the row two up, lower byte the row one up
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] mem_rdata;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [2*PIX_W-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_rdata <= line_mem[c_cur[ADDR_W-1:0]];
    end
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
  end

  // Read stage: pixel waiting for its line RAM data
  logic               s1_valid;
  logic [PIX_W-1:0]   s1_px;
  logic [ADDR_W-1:0]  s1_addr;
  logic               s1_emit;
  logic               s1_last;
  logic [ROW_W-1:0]   s1_row;
  logic [COL_W-1:0]   s1_col;
  logic               s1_fwd;
  logic [2*PIX_W-1:0] s1_fwd_data;
  logic [PIX_W-1:0]   s1_top;
  logic [PIX_W-1:0]   s1_mid;

  // Same column written by the word ahead: the RAM read returns stale data
  assign {s1_top, s1_mid} = s1_fwd ? s1_fwd_data : mem_rdata;

  assign mem_we    = s1_valid && advance;
  assign mem_waddr = s1_addr;
  assign mem_wdata = {s1_mid, s1_px};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px       <= in_data.pixel;
      s1_addr     <= c_cur[ADDR_W-1:0];
      s1_emit     <= (r_cur >= ROW_W'(2)) && (c_cur >= COL_W'(2));
      s1_last     <= frame_end;
      s1_row      <= r_cur - ROW_W'(1);
      s1_col      <= c_cur - COL_W'(1);
      s1_fwd      <= s1_valid && (s1_addr == c_cur[ADDR_W-1:0]);
      s1_fwd_data <= {s1_mid, s1_px};
    end
  end

  // 3x3 window, row 0 on top, newest column on the right
  logic [PIX_W-1:0] window      [9];
  logic [PIX_W-1:0] window_next [9];

  always_comb begin
    window_next[0] = window[1];
    window_next[1] = window[2];
    window_next[2] = s1_top;
    window_next[3] = window[4];
    window_next[4] = window[5];
    window_next[5] = s1_mid;
    window_next[6] = window[7];
    window_next[7] = window[8];
    window_next[8] = s1_px;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        window[i] <= '0;
      end
    end else if (mem_we) begin
      for (int i = 0; i < 9; i++) begin
        window[i] <= window_next[i];
      end
    end
  end

  // Median stage: four directional medians through the centre
  logic             s2_valid;
  logic [PIX_W-1:0] s2_z1;
  logic [PIX_W-1:0] s2_z2;
  logic [PIX_W-1:0] s2_z3;
  logic [PIX_W-1:0] s2_z4;
  logic             s2_last;
  logic [ROW_W-1:0] s2_row;
  logic [COL_W-1:0] s2_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      s2_z1   <= med3(window_next[1], window_next[4], window_next[7]);
      s2_z2   <= med3(window_next[3], window_next[4], window_next[5]);
      s2_z3   <= med3(window_next[0], window_next[4], window_next[8]);
      s2_z4   <= med3(window_next[2], window_next[4], window_next[6]);
      s2_last <= s1_last;
      s2_row  <= s1_row;
      s2_col  <= s1_col;
    end
  end

  // Output register: max of the four medians
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_valid) begin
      out_data.filtered   <= max2(max2(s2_z1, s2_z2), max2(s2_z3, s2_z4));
      out_data.out_row    <= s2_row;
      out_data.out_col    <= s2_col;
      out_data.frame_last <= s2_last;
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import mmf3_pkg::*;

  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_PIXELS = 300;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  in_word_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_word_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  max_median_filter_3x3_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Filter state as the testbench sees it
  logic [PIX_W-1:0]    row_above2 [MAX_WIDTH];
  logic [PIX_W-1:0]    row_above1 [MAX_WIDTH];
  logic [PIX_W-1:0]    win [9];
  int unsigned         pos_col = 0;
  int unsigned         pos_row = 0;
  logic [WIDTH_W-1:0]  width_reg = WIDTH_RESET;
  logic [HEIGHT_W-1:0] height_reg = HEIGHT_RESET;

  out_word_t expected_words[$];

  int burst_left = 0;
  int pixels_sent = 0;
  int words_seen = 0;
  int reg_writes = 0;
  int mismatches = 0;
  int stall_mode = 0;
  int stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Width and height after clamping
  function automatic int unsigned eff_width();
    if (width_reg < 3) return 3;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg < 3) return 3;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return 32'(height_reg);
  endfunction

  function automatic logic [PIX_W-1:0] median3(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b,
                                               input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] mn;
    logic [PIX_W-1:0] mx;
    logic [PIX_W-1:0] m2;
    mn = (a < b) ? a : b;
    mx = (a < b) ? b : a;
    m2 = (mx < c) ? mx : c;
    return (mn > m2) ? mn : m2;
  endfunction

  // Advance the filter by one pixel; queue the result word if one is due
  task automatic filter_pixel(input logic [PIX_W-1:0] px, input logic fs);
    int unsigned      w;
    int unsigned      h;
    int unsigned      c;
    int unsigned      r;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] best;
    logic [PIX_W-1:0] dir_med [4];
    bit               row_end;
    bit               frame_end;
    out_word_t        res;
    w = eff_width();
    h = eff_height();
    if (fs) begin
      pos_col = 0;
      pos_row = 0;
    end
    c = pos_col;
    r = pos_row;
    top = row_above2[c];
    mid = row_above1[c];
    row_above2[c] = mid;
    row_above1[c] = px;
    // shift window left, newest column on the right
    for (int k = 0; k < 3; k++) begin
      win[3*k]   = win[3*k+1];
      win[3*k+1] = win[3*k+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = px;
    row_end = (c + 1 >= w);
    frame_end = row_end && (r + 1 >= h);
    if (r >= 2 && c >= 2) begin
      dir_med[0] = median3(win[1], win[4], win[7]);
      dir_med[1] = median3(win[3], win[4], win[5]);
      dir_med[2] = median3(win[0], win[4], win[8]);
      dir_med[3] = median3(win[2], win[4], win[6]);
      best = dir_med[0];
      for (int k = 1; k < 4; k++) begin
        if (dir_med[k] > best) best = dir_med[k];
      end
      res.filtered   = best;
      res.out_row    = ROW_W'(r - 1);
      res.out_col    = COL_W'(c - 1);
      res.frame_last = frame_end;
      expected_words.push_back(res);
    end
    if (frame_end) begin
      pos_col = 0;
      pos_row = 0;
    end else if (row_end) begin
      pos_col = 0;
      pos_row = (r + 1) & 32'hFFF;
    end else begin
      pos_col = (c + 1) & 32'h1FF;
    end
  endtask

  // One pixel word; the sender runs in bursts with random gaps
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      case ($urandom_range(0, 5))
        0: begin
          burst_left = $urandom_range(100, 300);
        end
        1, 2: begin
          gap = $urandom_range(1, 2);
          burst_left = $urandom_range(1, 8);
        end
        3: begin
          gap = $urandom_range(3, 10);
          burst_left = $urandom_range(1, 20);
        end
        default: begin
          burst_left = $urandom_range(1, 20);
        end
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_data <= '{pixel: px, frame_start: fs};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    filter_pixel(px, fs);
    burst_left--;
    pixels_sent++;
  endtask

  // Stop sending and wait until every queued result word has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_IMAGE_WIDTH) begin
      width_reg = val[WIDTH_W-1:0];
    end else begin
      height_reg = val[HEIGHT_W-1:0];
    end
    reg_writes++;
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(input int style);
    case (style)
      1: return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
      2: return PIX_W'($urandom_range(120, 123));
      3: return PIX_W'(1) << $urandom_range(0, 7);
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // 3x3 frames that favor one direction each; centre 100, arms above it
  function automatic logic [PIX_W-1:0] pattern_pixel(input int pat, input int i);
    if (i == 4) return 8'd100;
    case (pat)
      0: return (i == 1 || i == 7) ? 8'd200 : 8'd0;
      1: return (i == 3 || i == 5) ? 8'd210 : 8'd0;
      2: return (i == 0 || i == 8) ? 8'd220 : 8'd0;
      default: return (i == 2 || i == 6) ? 8'd255 : 8'd0;
    endcase
  endfunction

  // Reset size 496 x 372: part of the first row, then shrink the width and
  // later the height while the position is past the new limits
  task automatic test_default_size();
    for (int i = 0; i < 40; i++) send_pixel(pick_pixel(i % 4), i == 0);
    drain();
    write_reg(CFG_IMAGE_WIDTH, CFG_W'(5));
    // column 40 ends row 0; rows 1 to 3 are five wide, row 4 stops at column 1
    for (int i = 0; i < 18; i++) send_pixel(pick_pixel(i % 4), 1'b0);
    drain();
    write_reg(CFG_IMAGE_HEIGHT, CFG_W'(2));
    for (int i = 0; i < 3; i++) send_pixel(pick_pixel(0), 1'b0);
  endtask

  // Clamped minimum frame, one frame per median direction
  task automatic test_small_windows();
    drain();
    write_reg(CFG_IMAGE_WIDTH, CFG_W'(2));
    write_reg(CFG_IMAGE_HEIGHT, CFG_W'(0));
    // aborted start, then restart with frame_start
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'h00, 1'b0);
    for (int pat = 0; pat < 4; pat++) begin
      for (int i = 0; i < 9; i++) begin
        // last frame follows on from the wrap, no frame_start
        send_pixel(pattern_pixel(pat, i), i == 0 && pat != 3);
      end
    end
  endtask

  // Out-of-range values clamp to 512 columns and 4096 rows
  task automatic test_max_size();
    drain();
    write_reg(CFG_IMAGE_WIDTH, {CFG_W{1'b1}});
    write_reg(CFG_IMAGE_HEIGHT, {CFG_W{1'b1}});
    for (int i = 0; i < MAX_WIDTH + 10; i++) send_pixel(pick_pixel(i % 4), i == 0);
    drain();
    write_reg(CFG_IMAGE_WIDTH, CFG_W'(4));
    write_reg(CFG_IMAGE_HEIGHT, CFG_W'(3));
    // column 10 ends row 1, then one last row of four
    for (int i = 0; i < 5; i++) send_pixel(pick_pixel(0), 1'b0);
  endtask

  // Random sizes and content, whole frames, some aborted and restarted
  task automatic test_random_frames();
    int          first;
    int unsigned w;
    int unsigned h;
    int unsigned npix;
    int unsigned cut;
    int          style;
    bit          restart;
    first = pixels_sent;
    while (pixels_sent - first < RANDOM_PIXELS) begin
      if ($urandom_range(0, 9) < 7) begin
        drain();
        case ($urandom_range(0, 9))
          0: w = $urandom_range(0, 2);
          1: w = $urandom_range(33, 80);
          default: w = $urandom_range(3, 16);
        endcase
        h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
        write_reg(CFG_IMAGE_WIDTH, CFG_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, CFG_W'(h));
      end
      repeat ($urandom_range(1, 3)) begin
        style = $urandom_range(0, 3);
        npix = eff_width() * eff_height();
        restart = ($urandom_range(0, 9) == 0);
        if (restart) begin
          cut = $urandom_range(1, npix - 1);
          for (int i = 0; i < cut; i++) send_pixel(pick_pixel(style), i == 0);
        end
        for (int i = 0; i < npix; i++) begin
          send_pixel(pick_pixel(style),
                     i == 0 && (restart || $urandom_range(0, 3) != 0));
        end
      end
    end
  endtask

  // Receiver: the stall pattern is picked anew at random intervals
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(32, 256);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (stall_left % 5 != 0);
    endcase
  end

  // Compare each result word with the oldest queued one
  always @(posedge clk) begin : check_words
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected word filtered=%0d row=%0d col=%0d last=%0b", $time,
                   out_data.filtered, out_data.out_row, out_data.out_col,
                   out_data.frame_last);
        end
      end else begin
        want = expected_words.pop_front();
        if (out_data.filtered !== want.filtered || out_data.out_row !== want.out_row ||
            out_data.out_col !== want.out_col || out_data.frame_last !== want.frame_last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: expected filtered=%0d row=%0d col=%0d last=%0b", $time,
                     want.filtered, want.out_row, want.out_col, want.frame_last);
            $display("%0t:   actual filtered=%0d row=%0d col=%0d last=%0b", $time,
                     out_data.filtered, out_data.out_row, out_data.out_col,
                     out_data.frame_last);
          end
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    out_ready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data <= '0;
    foreach (win[k]) win[k] = '0;
    foreach (row_above2[k]) row_above2[k] = '0;
    foreach (row_above1[k]) row_above1[k] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_default_size();
    test_small_windows();
    test_max_size();
    test_random_frames();
    drain();

    $display("Sent %0d pixel words, checked %0d result words, %0d register writes",
             pixels_sent, words_seen, reg_writes);
    $display("Sizes from the clamped 3x3 minimum to 512 columns, shrink mid-frame included");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("Timeout with %0d result words outstanding", expected_words.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
